/* rtl/core/assert_macros.svh */
// Assertion helpers; clk_i and rst_ni must exist in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned ArenaBytes  = 4096;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned AddrW       = $clog2(ArenaBytes);
  // wide enough for a header offset plus header plus payload
  localparam int unsigned PtrW        = AddrW + 2;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNoFit     = 2'd1,
    StBadAddr   = 2'd2,
    StDoubleFree = 2'd3
  } status_e;

  // one memory word per arena offset
  typedef struct packed {
    logic             hdr;
    logic             used;
    logic [AddrW-1:0] size;
    logic [AddrW-1:0] prev;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    entry_t           wdata;
  } mem_req_t;

endpackage

/* rtl/core/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/core/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: clears the arena table, walks block headers for an allocate,
// and does the split or the two-sided merge with read-modify-write steps.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [AddrW-1:0] request_size_i,
  input  logic [AddrW-1:0] free_address_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [AddrW-1:0] res_address_o,
  output status_e          res_status_o,
  output mem_req_t         mem_req_o,
  input  entry_t           mem_rdata_i
);

  typedef enum logic [19:0] {
    SClear  = 20'h00001,
    SIdle   = 20'h00002,
    SARd    = 20'h00004,
    SAChk   = 20'h00008,
    SANxRd  = 20'h00010,
    SANxWr  = 20'h00020,
    SANWr   = 20'h00040,
    SAHWr   = 20'h00080,
    SFRd    = 20'h00100,
    SFChk   = 20'h00200,
    SFNRd   = 20'h00400,
    SFNChk  = 20'h00800,
    SFNnRd  = 20'h01000,
    SFNnWr  = 20'h02000,
    SFPv    = 20'h04000,
    SFPChk  = 20'h08000,
    SFXRd   = 20'h10000,
    SFXWr   = 20'h20000,
    SFHWr   = 20'h40000,
    SDone   = 20'h80000
  } state_e;

  localparam logic [PtrW-1:0] HdrP   = PtrW'(HeaderBytes);
  localparam logic [PtrW-1:0] ArenaP = PtrW'(ArenaBytes);

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [PtrW-1:0]  h_q, h_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] n_q, n_d;
  logic [AddrW-1:0] rem_q, rem_d;
  logic [AddrW-1:0] req_q, req_d;
  logic [AddrW-1:0] last_q, last_d;
  entry_t           cur_q, cur_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  status_e          res_st_q, res_st_d;

  entry_t           e;
  logic [AddrW-1:0] h12;
  logic [PtrW-1:0]  nxt_h;
  logic [AddrW-1:0] diff;
  logic [AddrW-1:0] merged;
  logic [PtrW-1:0]  nn;
  logic [AddrW-1:0] pmerged;
  logic [PtrW-1:0]  pnx;
  logic [AddrW-1:0] p_off;

  assign e       = mem_rdata_i;
  assign h12     = h_q[AddrW-1:0];
  assign nxt_h   = h_q + HdrP + PtrW'(e.size);
  assign diff    = e.size - req_q;
  assign merged  = cur_q.size + AddrW'(HeaderBytes) + e.size;
  assign nn      = h_q + HdrP + PtrW'(merged);
  assign pmerged = e.size + AddrW'(HeaderBytes) + cur_q.size;
  assign pnx     = PtrW'(cur_q.prev) + HdrP + PtrW'(pmerged);
  assign p_off   = free_address_i - AddrW'(HeaderBytes);

  assign in_ready_o    = (state_q == SIdle);
  assign res_valid_o   = (state_q == SDone);
  assign res_address_o = res_addr_q;
  assign res_status_o  = res_st_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    h_d        = h_q;
    ptr_d      = ptr_q;
    n_d        = n_q;
    rem_d      = rem_q;
    req_d      = req_q;
    last_d     = last_q;
    cur_d      = cur_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    mem_req_o  = '0;

    unique case (state_q)
      SClear: begin
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = clr_q;
        if (clr_q == '0) begin
          mem_req_o.wdata.hdr  = 1'b1;
          mem_req_o.wdata.size = AddrW'(ArenaBytes - HeaderBytes);
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(ArenaBytes - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          req_d      = request_size_i;
          res_addr_d = '0;
          if (action_i == ActAlloc) begin
            h_d     = '0;
            state_d = SARd;
          end else if (free_address_i < AddrW'(HeaderBytes) || p_off > last_q) begin
            res_st_d = StBadAddr;
            state_d  = SDone;
          end else begin
            h_d     = PtrW'(p_off);
            state_d = SFRd;
          end
        end
      end
      SARd: begin
        mem_req_o.addr = h12;
        state_d        = SAChk;
      end
      SAChk: begin
        cur_d = e;
        if (!e.used && e.size >= req_q) begin
          if (diff > AddrW'(HeaderBytes)) begin
            // split; the remainder header always lands inside the arena
            n_d        = AddrW'(h_q + HdrP + PtrW'(req_q));
            rem_d      = diff - AddrW'(HeaderBytes);
            cur_d.size = req_q;
            if (h12 != last_q) begin
              if (nxt_h < ArenaP) begin
                ptr_d   = nxt_h[AddrW-1:0];
                state_d = SANxRd;
              end else begin
                state_d = SANWr;
              end
            end else begin
              last_d  = AddrW'(h_q + HdrP + PtrW'(req_q));
              state_d = SANWr;
            end
          end else begin
            state_d = SAHWr;
          end
        end else if (h12 == last_q || nxt_h >= ArenaP) begin
          res_st_d = StNoFit;
          state_d  = SDone;
        end else begin
          h_d     = nxt_h;
          state_d = SARd;
        end
      end
      SANxRd: begin
        mem_req_o.addr = ptr_q;
        state_d        = SANxWr;
      end
      SANxWr: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.addr       = ptr_q;
        mem_req_o.wdata      = e;
        mem_req_o.wdata.prev = n_q;
        state_d              = SANWr;
      end
      SANWr: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.addr       = n_q;
        mem_req_o.wdata.hdr  = 1'b1;
        mem_req_o.wdata.used = 1'b0;
        mem_req_o.wdata.size = rem_q;
        mem_req_o.wdata.prev = h12;
        state_d              = SAHWr;
      end
      SAHWr: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.addr       = h12;
        mem_req_o.wdata      = cur_q;
        mem_req_o.wdata.used = 1'b1;
        res_addr_d           = h12 + AddrW'(HeaderBytes);
        res_st_d             = StOk;
        state_d              = SDone;
      end
      SFRd: begin
        mem_req_o.addr = h12;
        state_d        = SFChk;
      end
      SFChk: begin
        if (!e.hdr) begin
          res_st_d = StBadAddr;
          state_d  = SDone;
        end else if (!e.used) begin
          res_st_d = StDoubleFree;
          state_d  = SDone;
        end else begin
          cur_d      = e;
          cur_d.used = 1'b0;
          if (h12 != last_q && nxt_h < ArenaP) begin
            ptr_d   = nxt_h[AddrW-1:0];
            state_d = SFNRd;
          end else begin
            state_d = SFPv;
          end
        end
      end
      SFNRd: begin
        mem_req_o.addr = ptr_q;
        state_d        = SFNChk;
      end
      SFNChk: begin
        state_d = SFPv;
        if (!e.used) begin
          cur_d.size          = merged;
          mem_req_o.we        = 1'b1;
          mem_req_o.addr      = ptr_q;
          mem_req_o.wdata     = e;
          mem_req_o.wdata.hdr = 1'b0;
          if (ptr_q == last_q) begin
            last_d = h12;
          end else if (nn < ArenaP) begin
            ptr_d   = nn[AddrW-1:0];
            state_d = SFNnRd;
          end
        end
      end
      SFNnRd: begin
        mem_req_o.addr = ptr_q;
        state_d        = SFNnWr;
      end
      SFNnWr: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.addr       = ptr_q;
        mem_req_o.wdata      = e;
        mem_req_o.wdata.prev = h12;
        state_d              = SFPv;
      end
      SFPv: begin
        mem_req_o.addr = cur_q.prev;
        state_d        = (h12 == '0) ? SFHWr : SFPChk;
      end
      SFPChk: begin
        state_d = SFHWr;
        if (!e.used) begin
          mem_req_o.we         = 1'b1;
          mem_req_o.addr       = cur_q.prev;
          mem_req_o.wdata      = e;
          mem_req_o.wdata.size = pmerged;
          cur_d.hdr            = 1'b0;
          if (h12 == last_q) begin
            last_d = cur_q.prev;
          end else if (pnx < ArenaP) begin
            ptr_d   = pnx[AddrW-1:0];
            state_d = SFXRd;
          end
        end
      end
      SFXRd: begin
        mem_req_o.addr = ptr_q;
        state_d        = SFXWr;
      end
      SFXWr: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.addr       = ptr_q;
        mem_req_o.wdata      = e;
        mem_req_o.wdata.prev = cur_q.prev;
        state_d              = SFHWr;
      end
      SFHWr: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = h12;
        mem_req_o.wdata = cur_q;
        res_st_d        = StOk;
        state_d         = SDone;
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q        <= h_d;
    ptr_q      <= ptr_d;
    n_q        <= n_d;
    rem_q      <= rem_d;
    req_q      <= req_d;
    cur_q      <= cur_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
  end

endmodule

/* rtl/core/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit arena allocator with block split and two-sided coalescing.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one request word: action_i
// selects allocate or free, request_size_i is the payload size of an
// allocate, free_address_i the payload address of a free. Output channel
// (out_valid_o/out_ready_i) returns one word per request: address_o and
// status_o.
// One request is in flight at a time. An allocate reads and checks each block
// header visited (one RAM read plus a check), then writes any split and the
// header; a free runs read-modify-write steps, all set by the single RAM port.
// The result waits in the done state until the output register takes it, and
// the next request is taken while the result waits in the output register for
// out_ready_i.
// After reset the header table RAM is cleared, one entry a cycle; in_ready_o
// stays low during that pass. A stalled receiver holds only the output
// register; a second result waits inside the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_block_allocator import ffba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [AddrW-1:0] request_size_i,
  input  logic [AddrW-1:0] free_address_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] address_o,
  output logic [1:0]       status_o
);

  mem_req_t          mem_req;
  logic [EntryW-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  logic [AddrW-1:0]  res_address;
  status_e           res_status;

  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  status_e           out_st_q;

  ffba_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .request_size_i,
    .free_address_i,
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_address_o (res_address),
    .res_status_o  (res_status),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (entry_t'(ram_rdata))
  );

  ffba_ram #(
    .Depth (ArenaBytes),
    .Width (EntryW)
  ) u_ram (
    .clk_i,
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_addr_q <= res_address;
      out_st_q   <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = out_addr_q;
  assign status_o    = out_st_q;

  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
               "allocator took a second word right after an accept")
  `ASSERT_IMPL(a_err_addr_zero, out_valid_o && status_o != StOk, address_o == '0,
               "error or no-fit result carries a nonzero address")
  `ASSERT_IMPL(a_ok_addr_past_hdr, out_valid_o && status_o == StOk && address_o != '0,
               address_o >= AddrW'(HeaderBytes), "allocated address inside first header")

endmodule
